>>> rtl/rsv_pkg.sv
package rsv_pkg;

  localparam int DATA_W         = 32;
  localparam int LANE_COUNT_DEF = 8;

  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

>>> rtl/rsv_intf.sv
interface rsv_in_if #(parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF);
  logic                                valid;
  logic                                ready;
  rsv_pkg::elem_t [LANE_COUNT-1:0]     value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rsv_out_if #(parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF);
  logic                                valid;
  logic                                ready;
  rsv_pkg::elem_t [LANE_COUNT-1:0]     sorted;

  modport source (output valid, output sorted, input ready);
  modport sink   (input valid, input sorted, output ready);
endinterface

>>> rtl/rank_sort_vector_unit.sv
// Rank sort of one vector of LANE_COUNT signed 32-bit values.
// Channels: vec (sink) carries one word of LANE_COUNT values, result
// (source) carries one word with the same values in ascending order;
// equal values keep their input order. Both use valid/ready, a word moves
// on a clock edge with both high.
// An accepted word passes stage one, which holds the per-lane ranks (one
// compare row and a bit count per lane), then stage two, the scattered
// output. Throughput: one word per cycle while result.ready is high.
// Stalls: when result.ready is low the output word holds; vec.ready stays
// high while stage one is empty or can move into a free output register,
// so up to two words are held before input stops.
// Reset (rst, synchronous, active high) empties both stages; the block
// keeps no other state.
module rank_sort_vector_unit #(
  parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rsv_in_if.sink      vec,
  rsv_out_if.source   result
);

  localparam int RANK_W = $clog2(LANE_COUNT);

  logic                                      s1_valid;
  rsv_pkg::elem_t [LANE_COUNT-1:0]           s1_value;
  logic [LANE_COUNT-1:0][RANK_W-1:0]         s1_rank;
  logic [LANE_COUNT-1:0][RANK_W-1:0]         rank_next;
  rsv_pkg::elem_t [LANE_COUNT-1:0]           sorted_next;
  logic                                      out_free;
  logic                                      s1_free;

  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    rsv_lane #(.LANE_COUNT(LANE_COUNT), .LANE(l)) u_lane (
      .value (vec.value),
      .rank  (rank_next[l])
    );
  end

  rsv_merge #(.LANE_COUNT(LANE_COUNT)) u_merge (
    .value  (s1_value),
    .rank   (s1_rank),
    .sorted (sorted_next)
  );

  assign out_free  = !result.valid || result.ready;
  assign s1_free   = !s1_valid || out_free;
  assign vec.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= vec.valid;
    end
    if (s1_free && vec.valid) begin
      s1_value <= vec.value;
      s1_rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      result.sorted <= sorted_next;
    end
  end

endmodule

>>> rtl/rsv_lane.sv
module rsv_lane #(
  parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF,
  parameter int LANE       = 0
) (
  input  rsv_pkg::elem_t [LANE_COUNT-1:0]  value,
  output logic [$clog2(LANE_COUNT)-1:0]    rank
);

  localparam int RANK_W = $clog2(LANE_COUNT);

  logic [LANE_COUNT-1:0] below;

  // ties go to the lower lane
  always_comb begin
    for (int j = 0; j < LANE_COUNT; j++) begin
      if (j < LANE) begin
        below[j] = ($signed(value[j]) <= $signed(value[LANE]));
      end else if (j > LANE) begin
        below[j] = ($signed(value[j]) < $signed(value[LANE]));
      end else begin
        below[j] = 1'b0;
      end
    end
  end

  always_comb begin
    rank = '0;
    for (int j = 0; j < LANE_COUNT; j++) begin
      rank = rank + RANK_W'(below[j]);
    end
  end

endmodule

>>> rtl/rsv_merge.sv
module rsv_merge #(
  parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF
) (
  input  rsv_pkg::elem_t [LANE_COUNT-1:0]                 value,
  input  logic [LANE_COUNT-1:0][$clog2(LANE_COUNT)-1:0]   rank,
  output rsv_pkg::elem_t [LANE_COUNT-1:0]                 sorted
);

  localparam int RANK_W = $clog2(LANE_COUNT);

  // ranks are a permutation, so each slot gets exactly one lane
  always_comb begin
    for (int s = 0; s < LANE_COUNT; s++) begin
      sorted[s] = '0;
      for (int l = 0; l < LANE_COUNT; l++) begin
        if (rank[l] == RANK_W'(s)) begin
          sorted[s] = sorted[s] | value[l];
        end
      end
    end
  end

endmodule

>>> rtl/rsv_check.sv
module rsv_check #(
  parameter int LANE_COUNT = rsv_pkg::LANE_COUNT_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              vec_valid,
  input logic                              vec_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input rsv_pkg::elem_t [LANE_COUNT-1:0]   res_sorted
);

  logic [1:0] inflight;
  logic       in_fire;
  logic       out_fire;
  logic       ordered;

  assign in_fire  = vec_valid && vec_ready;
  assign out_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 2'(in_fire) - 2'(out_fire);
    end
  end

  always_comb begin
    ordered = 1'b1;
    for (int k = 0; k < LANE_COUNT - 1; k++) begin
      if ($signed(res_sorted[k]) > $signed(res_sorted[k+1])) begin
        ordered = 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sorted))
    else $error("result word changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ordered)
    else $error("result word not in ascending order");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> inflight != 2'd0)
    else $error("result word without accepted input");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd2 |-> !vec_ready || res_ready)
    else $error("more than two words held");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    inflight == 2'd0 |-> vec_ready)
    else $error("input stalled while empty");

endmodule

bind rank_sort_vector_unit rsv_check #(.LANE_COUNT(LANE_COUNT)) u_check (
  .clk        (clk),
  .rst        (rst),
  .vec_valid  (vec.valid),
  .vec_ready  (vec.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_sorted (result.sorted)
);
